// ===== rtl/rgb_to_hsi_converter_assert.svh =====
// Assertion macros for the RGB to HSI converter.
// Both expect a signal named clk, and RHC_ASSERT also rst_n, in the scope where they are used.
`ifndef RGB_TO_HSI_CONVERTER_ASSERT_SVH
`define RGB_TO_HSI_CONVERTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define RHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rgb_to_hsi_converter: assertion failed");
// Checked at every edge, reset included.
`define RHC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rgb_to_hsi_converter: assertion failed");
`else
`define RHC_ASSERT(lbl, prop)
`define RHC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/rgbhsi_pkg.sv =====
package rgbhsi_pkg;

  // Number of CORDIC iterations, one pipeline stage each.
  localparam int CORDIC_STEPS = 18;
  localparam int STEP_W       = 5;

  // Angle accumulator: units of 2^-18 degree, signed.
  localparam int ZW      = 28;
  localparam int ANG_90  = 23592960;
  localparam int ANG_180 = 47185920;

  // sqrt(3) in Q14.
  localparam int SQRT3_Q14 = 28378;

  // Result field widths and limits.
  localparam int HUE_W     = 15;
  localparam int SAT_W     = 13;
  localparam int INT_W     = 10;
  localparam int THETA_W   = 14;
  localparam int HUE_FULL  = 23040;
  localparam int SAT_ONE   = 4096;
  localparam int INT_FULL  = 1020;

  // Per-item flags that travel alongside the CORDIC and dividers.
  typedef struct packed {
    logic achro;
    logic mirror;
    logic sum_zero;
    logic frame_end;
  } side_t;

  // atan(2^-i) in 2^-18 degree units, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] v;
    v = '0;
    case (idx)
      5'd0:    v = 28'sd11796480;
      5'd1:    v = 28'sd6963869;
      5'd2:    v = 28'sd3679517;
      5'd3:    v = 28'sd1867780;
      5'd4:    v = 28'sd937515;
      5'd5:    v = 28'sd469214;
      5'd6:    v = 28'sd234664;
      5'd7:    v = 28'sd117339;
      5'd8:    v = 28'sd58671;
      5'd9:    v = 28'sd29335;
      5'd10:   v = 28'sd14668;
      5'd11:   v = 28'sd7334;
      5'd12:   v = 28'sd3667;
      5'd13:   v = 28'sd1833;
      5'd14:   v = 28'sd917;
      5'd15:   v = 28'sd458;
      5'd16:   v = 28'sd229;
      5'd17:   v = 28'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rgbhsi_if.sv =====
// Pixel input channel.
interface rgbhsi_in_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  logic                    frame_end_in;

  modport source (output valid, red, green, blue, frame_end_in, input ready);
  modport sink   (input valid, red, green, blue, frame_end_in, output ready);
endinterface

// HSI result channel.
interface rgbhsi_out_if
  import rgbhsi_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [INT_W-1:0] intensity;
  logic             achromatic;
  logic             frame_end_out;

  modport source (output valid, hue, saturation, intensity, achromatic, frame_end_out,
                  input ready);
  modport sink   (input valid, hue, saturation, intensity, achromatic, frame_end_out,
                  output ready);
endinterface

// ===== rtl/rgb_to_hsi_converter.sv =====
// RGB to HSI pixel converter. One pixel is accepted per clock, and each pixel
// passes in order through an input register, one stage that forms the channel
// sum, minimum and CORDIC start vector, 18 CORDIC stages for the hue angle
// (saturation divides in parallel, one quotient bit a stage, and intensity is a
// reciprocal multiplication followed by delay stages) and the output register.
// When the result side holds back ready on a valid result, the whole pipeline
// freezes in place and in_px.ready falls in the same cycle.
// Hue is in 1/64 degree, saturation in 1/4096, intensity scaled so full scale
// reads 1020; gray pixels give hue 0 with achromatic set.
module rgb_to_hsi_converter
  import rgbhsi_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  rgbhsi_in_if.sink    in_px,
  rgbhsi_out_if.source out_px
);

  localparam int CB     = CHANNEL_BITS;
  localparam int CMASK  = (1 << CB) - 1;
  localparam int SUMW   = CB + 2;
  localparam int XW     = CB + 19;
  localparam int SDW    = SUMW + 14;
  localparam int SVW    = SUMW + 1;
  localparam int IDW    = CB + 13;
  localparam int PIPE   = CORDIC_STEPS + 2;
  localparam int SIDE_N = CORDIC_STEPS + 1;

  // Reciprocal of the intensity divisor 6 * full scale, exact for every
  // dividend that the channel sum can produce.
  localparam int     IRK = 2 * CB + 16;
  localparam int     IRW = CB + 15;
  localparam int     IPW = IDW + IRW;
  localparam longint IRD = longint'(6 * CMASK);
  localparam longint IRM = ((64'sd1 <<< IRK) + IRD - 64'sd1) / IRD;

  logic en;
  logic in_acc;

  logic [PIPE-1:0] vld_r;
  logic            out_vld_r;

  // Pipeline advances whenever the output register is empty or being taken.
  assign en     = out_px.ready || !out_vld_r;
  assign in_acc = in_px.valid && en;
  assign in_px.ready = en;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[PIPE-2:0], in_acc};
      out_vld_r <= vld_r[PIPE-1];
    end
  end

  // Input register.
  logic [CB-1:0] r0_r, g0_r, b0_r;
  logic          fe0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r  <= in_px.red;
      g0_r  <= in_px.green;
      b0_r  <= in_px.blue;
      fe0_r <= in_px.frame_end_in;
    end
  end

  // Channel sum, minimum, and the CORDIC start vector.
  logic [SUMW-1:0]     sum_c;
  logic [CB-1:0]       mn_c;
  logic [CB-1:0]       ad_c;
  logic signed [CB+2:0] xd_c;
  logic signed [XW-1:0] xs_c, ys_c;
  logic                 x_neg;
  logic [SUMW-1:0]     min3_c;
  side_t               side_c;

  always_comb begin
    sum_c  = SUMW'(r0_r) + SUMW'(g0_r) + SUMW'(b0_r);
    mn_c   = (r0_r < g0_r) ? r0_r : g0_r;
    if (mn_c > b0_r) begin
      mn_c = b0_r;
    end
    min3_c = SUMW'(mn_c) + SUMW'({mn_c, 1'b0});
    ad_c   = (g0_r > b0_r) ? g0_r - b0_r : b0_r - g0_r;
    xd_c   = $signed({2'b00, r0_r, 1'b0}) - $signed({3'b000, g0_r})
             - $signed({3'b000, b0_r});
    xs_c   = XW'(xd_c) <<< 14;
    ys_c   = signed'(XW'(ad_c) * XW'(SQRT3_Q14));
    x_neg  = xs_c[XW-1];
    side_c.achro     = (r0_r == g0_r) && (g0_r == b0_r);
    side_c.mirror    = b0_r > g0_r;
    side_c.sum_zero  = (sum_c == '0);
    side_c.frame_end = fe0_r;
  end

  // Stage one registers. A start vector in the left half-plane is turned
  // by 90 degrees first so that the CORDIC converges.
  logic signed [XW-1:0] x1_r, y1_r;
  logic signed [ZW-1:0] z1_r;
  logic [SDW-1:0]       satd_r;
  logic [SVW-1:0]       satv_r;
  logic [IDW-1:0]       intd_r;
  side_t                side_r [SIDE_N];

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r      <= x_neg ? ys_c : xs_c;
      y1_r      <= x_neg ? -xs_c : ys_c;
      z1_r      <= x_neg ? ZW'(ANG_90) : '0;
      satd_r    <= (SDW'(sum_c - min3_c) << 13) + SDW'(sum_c);
      satv_r    <= {sum_c, 1'b0};
      intd_r    <= IDW'(sum_c) * IDW'(2 * INT_FULL) + IDW'(3 * CMASK);
      side_r[0] <= side_c;
      for (int k = 1; k < SIDE_N; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Hue angle.
  logic signed [ZW-1:0] z_fin;

  rgbhsi_cordic #(
    .XW (XW)
  ) u_cordic (
    .clk   (clk),
    .en    (en),
    .x_in  (x1_r),
    .y_in  (y1_r),
    .z_in  (z1_r),
    .z_out (z_fin)
  );

  // Saturation: round(4096 * (sum - 3 * min) / sum).
  logic [SAT_W-1:0] sat_q;

  rgbhsi_div #(
    .DW     (SDW),
    .VW     (SVW),
    .QB     (SAT_W),
    .STAGES (CORDIC_STEPS)
  ) u_sat_div (
    .clk      (clk),
    .en       (en),
    .dividend (satd_r),
    .divisor  (satv_r),
    .quotient (sat_q)
  );

  // Intensity: round(1020 * sum / (3 * full scale)) by multiplying with the
  // reciprocal, then delayed to line up with the hue.
  logic [IPW-1:0]   int_prod_c;
  logic [INT_W-1:0] int_pipe_r [CORDIC_STEPS];
  logic [INT_W-1:0] int_q;

  assign int_prod_c = IPW'(intd_r) * IPW'(IRM);

  always_ff @(posedge clk) begin
    if (en) begin
      int_pipe_r[0] <= int_prod_c[IRK +: INT_W];
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        int_pipe_r[k] <= int_pipe_r[k-1];
      end
    end
  end

  assign int_q = int_pipe_r[CORDIC_STEPS-1];

  // Clamp the angle to 0..180 degrees, round to 1/64 degree and mirror.
  side_t              side_f;
  logic [ZW-1:0]      zc_c;
  logic [ZW-1:0]      zr_c;
  logic [THETA_W-1:0] th_c;
  logic [HUE_W-1:0]   hue_c;

  always_comb begin
    side_f = side_r[SIDE_N-1];
    if (z_fin < 0) begin
      zc_c = '0;
    end else if (z_fin > ZW'(ANG_180)) begin
      zc_c = ZW'(ANG_180);
    end else begin
      zc_c = z_fin;
    end
    zr_c = zc_c + ZW'(2048);
    th_c = zr_c[12 +: THETA_W];
    if (side_f.achro) begin
      hue_c = '0;
    end else if (side_f.mirror) begin
      hue_c = (th_c == '0) ? '0 : HUE_W'(HUE_FULL) - HUE_W'(th_c);
    end else begin
      hue_c = HUE_W'(th_c);
    end
  end

  // Output register.
  logic [HUE_W-1:0] hue_r;
  logic [SAT_W-1:0] sat_r;
  logic [INT_W-1:0] int_r;
  logic             achro_r;
  logic             fe_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue_c;
      sat_r   <= side_f.sum_zero ? '0 : sat_q;
      int_r   <= int_q;
      achro_r <= side_f.achro;
      fe_r    <= side_f.frame_end;
    end
  end

  assign out_px.valid         = out_vld_r;
  assign out_px.hue           = hue_r;
  assign out_px.saturation    = sat_r;
  assign out_px.intensity     = int_r;
  assign out_px.achromatic    = achro_r;
  assign out_px.frame_end_out = fe_r;

  // Checks on the result values and on reset.
  `include "rgb_to_hsi_converter_assert.svh"

  `RHC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_px.valid)
  `RHC_ASSERT(a_gray_hue_zero, out_px.valid && out_px.achromatic |-> out_px.hue == '0)
  `RHC_ASSERT(a_hue_range, out_px.valid |-> out_px.hue < HUE_W'(HUE_FULL))
  `RHC_ASSERT(a_sat_range, out_px.valid |-> out_px.saturation <= SAT_W'(SAT_ONE))
  `RHC_ASSERT(a_int_range, out_px.valid |-> out_px.intensity <= INT_W'(INT_FULL))

endmodule

// ===== rtl/rgbhsi_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, then extra
// stages of delay, set by STAGES.
module rgbhsi_div #(
  parameter int DW     = 24,
  parameter int VW     = 11,
  parameter int QB     = 13,
  parameter int STAGES = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [QB-1:0] quotient
);

  localparam int CW  = (DW > VW + QB) ? DW : VW + QB;
  localparam int PAD = STAGES - QB;

  logic [CW-1:0] rem_r [QB-1];
  logic [VW-1:0] div_r [QB-1];
  logic [QB-1:0] quo_r [QB];

  // One trial subtraction per stage, most significant quotient bit first.
  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [CW-1:0] rem_i;
    logic [VW-1:0] div_i;
    logic [QB-1:0] quo_i;
    logic [CW-1:0] sub_v;

    if (s == 0) begin : g_first
      assign rem_i = CW'(dividend);
      assign div_i = divisor;
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign div_i = div_r[s-1];
      assign quo_i = quo_r[s-1];
    end

    assign sub_v = CW'(div_i) << (QB - 1 - s);

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= sub_v) begin
          quo_r[s] <= quo_i | (QB'(1) << (QB - 1 - s));
        end else begin
          quo_r[s] <= quo_i;
        end
      end
    end

    // The remainder and divisor are carried only to the stages that need them.
    if (s < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= (rem_i >= sub_v) ? rem_i - sub_v : rem_i;
          div_r[s] <= div_i;
        end
      end
    end
  end

  // Delay to line the quotient up with the rest of the pipeline.
  if (PAD > 0) begin : g_pad
    logic [QB-1:0] pad_r [PAD];
    always_ff @(posedge clk) begin
      if (en) begin
        pad_r[0] <= quo_r[QB-1];
        for (int k = 1; k < PAD; k++) begin
          pad_r[k] <= pad_r[k-1];
        end
      end
    end
    assign quotient = pad_r[PAD-1];
  end else begin : g_nopad
    assign quotient = quo_r[QB-1];
  end

endmodule

// ===== rtl/rgbhsi_cordic.sv =====
// Vectoring-mode CORDIC, one iteration per pipeline stage. It drives y to
// zero and accumulates the rotation angle in z.
module rgbhsi_cordic
  import rgbhsi_pkg::*;
#(
  parameter int XW = 27
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [ZW-1:0] z_out
);

  logic signed [XW-1:0] x_r [CORDIC_STEPS-1];
  logic signed [XW-1:0] y_r [CORDIC_STEPS-1];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [XW-1:0] x_i;
    logic signed [XW-1:0] y_i;
    logic signed [ZW-1:0] z_i;
    logic                 y_pos;

    if (i == 0) begin : g_first
      assign x_i = x_in;
      assign y_i = y_in;
      assign z_i = z_in;
    end else begin : g_next
      assign x_i = x_r[i-1];
      assign y_i = y_r[i-1];
      assign z_i = z_r[i-1];
    end

    assign y_pos = !y_i[XW-1];

    // Rotate toward the x axis; arithmetic shifts round toward minus infinity.
    always_ff @(posedge clk) begin
      if (en) begin
        z_r[i] <= y_pos ? z_i + atan_lut(STEP_W'(i)) : z_i - atan_lut(STEP_W'(i));
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_vec
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i] <= y_pos ? x_i + (y_i >>> i) : x_i - (y_i >>> i);
          y_r[i] <= y_pos ? y_i - (x_i >>> i) : y_i + (x_i >>> i);
        end
      end
    end
  end

  assign z_out = z_r[CORDIC_STEPS-1];

endmodule
